>>> rtl/spc_pkg.sv
package spc_pkg;

  // Default vertex coordinate width
  localparam int COORD_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_SURFACE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS_THRESHOLD  = 2'd2;

  localparam int SURFACE_W = 16;
  localparam int COS_W     = 16;
  localparam int COS_FRAC  = 15;

  localparam logic [SURFACE_W-1:0] TARGET_SURFACE_RST = 16'd0;
  localparam logic                 FILTER_ENABLE_RST  = 1'b0;
  localparam logic [COS_W-1:0]     COS_THRESHOLD_RST  = 16'sd32767;

  // Microprogram sequencing
  localparam int PROG_LEN = 26;
  localparam int STEP_W   = $clog2(PROG_LEN);

  typedef struct packed {
    logic [SURFACE_W-1:0]    target_surface;
    logic                    filter_enable;
    logic signed [COS_W-1:0] cos_threshold;
  } cfg_t;

  // Multiplier operand A sources
  typedef enum logic [3:0] {
    A_UX, A_UY, A_UZ, A_NX, A_NY, A_NZ, A_LEN_LO, A_LEN_HI,
    A_D_LO, A_D_HI, A_P0, A_P1, A_P2, A_P3
  } a_sel_t;

  // Multiplier operand B sources
  typedef enum logic [3:0] {
    B_VX, B_VY, B_VZ, B_NX, B_NY, B_NZ, B_RX, B_RY, B_RZ,
    B_RLEN_LO, B_RLEN_HI, B_D_LO, B_D_HI, B_CMAG
  } b_sel_t;

  // Accumulator store targets
  typedef enum logic [2:0] {
    ST_NONE, ST_NX, ST_NY, ST_NZ, ST_LEN, ST_D, ST_P, ST_D2
  } store_t;

  typedef struct packed {
    a_sel_t     a_sel;
    b_sel_t     b_sel;
    logic [1:0] shift;   // limb offset of the product in the accumulator
    logic       clr;     // start a new sum with this product
    logic       neg;     // subtract this product
    logic       acc_en;
    store_t     st;
    logic       ref_pt;  // squared length of the face normal is ready here
    logic       fin;
  } uop_t;

  typedef struct packed {
    uop_t op;
    logic capture;
    logic st_ref;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic kept;
    logic last;
    logic have_ref;
  } status_t;

  function automatic uop_t mk_op(a_sel_t a, b_sel_t b, logic [1:0] sh, logic clr,
                                 logic neg, store_t st);
    uop_t r;
    r.a_sel  = a;
    r.b_sel  = b;
    r.shift  = sh;
    r.clr    = clr;
    r.neg    = neg;
    r.acc_en = 1'b1;
    r.st     = st;
    r.ref_pt = 1'b0;
    r.fin    = 1'b0;
    return r;
  endfunction

  // Microprogram: a product passes the product register and then the accumulator
  // before a store can read it, so each store trails the last product of its sum.
  function automatic uop_t uop_at(logic [STEP_W-1:0] step);
    uop_t r;
    r = '0;
    unique case (step)
      // cross product n = u x v
      5'd0:  r = mk_op(A_UY, B_VZ, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd1:  r = mk_op(A_UZ, B_VY, 2'd0, 1'b0, 1'b1, ST_NONE);
      5'd2:  r = mk_op(A_UZ, B_VX, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd3:  r = mk_op(A_UX, B_VZ, 2'd0, 1'b0, 1'b1, ST_NX);
      5'd4:  r = mk_op(A_UX, B_VY, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd5:  r = mk_op(A_UY, B_VX, 2'd0, 1'b0, 1'b1, ST_NY);
      // squared length n.n
      5'd6:  r = mk_op(A_NX, B_NX, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd7:  r = mk_op(A_NY, B_NY, 2'd0, 1'b0, 1'b0, ST_NZ);
      5'd8:  r = mk_op(A_NZ, B_NZ, 2'd0, 1'b0, 1'b0, ST_NONE);
      // dot product with the reference
      5'd9:  r = mk_op(A_NX, B_RX, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd10: begin
        r = mk_op(A_NY, B_RY, 2'd0, 1'b0, 1'b0, ST_LEN);
        r.ref_pt = 1'b1;
      end
      5'd11: r = mk_op(A_NZ, B_RZ, 2'd0, 1'b0, 1'b0, ST_NONE);
      // length product, two limbs by two limbs
      5'd12: r = mk_op(A_LEN_LO, B_RLEN_LO, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd13: r = mk_op(A_LEN_LO, B_RLEN_HI, 2'd1, 1'b0, 1'b0, ST_D);
      5'd14: r = mk_op(A_LEN_HI, B_RLEN_LO, 2'd1, 1'b0, 1'b0, ST_NONE);
      5'd15: r = mk_op(A_LEN_HI, B_RLEN_HI, 2'd2, 1'b0, 1'b0, ST_NONE);
      // square of the dot magnitude
      5'd16: r = mk_op(A_D_LO, B_D_LO, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd17: r = mk_op(A_D_LO, B_D_HI, 2'd1, 1'b0, 1'b0, ST_P);
      5'd18: r = mk_op(A_D_HI, B_D_LO, 2'd1, 1'b0, 1'b0, ST_NONE);
      5'd19: r = mk_op(A_D_HI, B_D_HI, 2'd2, 1'b0, 1'b0, ST_NONE);
      // threshold magnitude times length product, four limbs
      5'd20: r = mk_op(A_P0, B_CMAG, 2'd0, 1'b1, 1'b0, ST_NONE);
      5'd21: r = mk_op(A_P1, B_CMAG, 2'd1, 1'b0, 1'b0, ST_D2);
      5'd22: r = mk_op(A_P2, B_CMAG, 2'd2, 1'b0, 1'b0, ST_NONE);
      5'd23: r = mk_op(A_P3, B_CMAG, 2'd3, 1'b0, 1'b0, ST_NONE);
      5'd24: r = '0;
      5'd25: begin
        r     = '0;
        r.fin = 1'b1;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/spc_datapath.sv
module spc_datapath #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spc_pkg::cfg_t                     cfg,
  input  spc_pkg::cmd_t                     cmd,
  output spc_pkg::status_t                  st,
  input  logic [spc_pkg::SURFACE_W-1:0]     face_surface,
  input  logic signed [COORD_BITS-1:0]      p1_x,
  input  logic signed [COORD_BITS-1:0]      p1_y,
  input  logic signed [COORD_BITS-1:0]      p1_z,
  input  logic signed [COORD_BITS-1:0]      p2_x,
  input  logic signed [COORD_BITS-1:0]      p2_y,
  input  logic signed [COORD_BITS-1:0]      p2_z,
  input  logic signed [COORD_BITS-1:0]      p3_x,
  input  logic signed [COORD_BITS-1:0]      p3_y,
  input  logic signed [COORD_BITS-1:0]      p3_z,
  input  logic                              last_face,
  output logic                              is_planar
);

  localparam int DW    = COORD_BITS + 1;      // edge vector component
  localparam int MW    = 2 * COORD_BITS + 2;  // normal component, limb width
  localparam int MOW   = MW + 1;              // signed multiplier operand
  localparam int LW    = 2 * MW;              // dot product magnitude
  localparam int PW    = 4 * MW;              // squared products
  localparam int ACC_W = 8 * COORD_BITS + 25;
  localparam int CM_W  = spc_pkg::COS_W + 1;

  // Face registers
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic                 kept, last;

  // Working registers
  logic signed [MW-1:0] nx, ny, nz;
  logic [LW-1:0]        len;
  logic [LW-1:0]        dmag;
  logic                 dneg;
  logic [PW-1:0]        plen;
  logic [PW-1:0]        d2;

  // Reference and flags
  logic signed [MW-1:0] ref_x, ref_y, ref_z;
  logic [LW-1:0]        ref_len;
  logic                 have_ref;
  logic                 dev;

  // Multiply-accumulate
  logic signed [MOW-1:0]   opa, opb;
  logic signed [2*MOW-1:0] prod;
  logic signed [ACC_W-1:0] acc, acc_next, term, shifted;
  logic [1:0]              shift_q;
  logic                    clr_q, neg_q, acc_en_q;

  // Threshold magnitude and verdict compare
  logic signed [CM_W-1:0] cos_ext;
  logic [CM_W-1:0]        cmag;
  logic                   cneg;
  logic [ACC_W-1:0]       amag, bmag;
  logic                   dev_now;

  assign st.kept     = kept;
  assign st.last     = last;
  assign st.have_ref = have_ref;

  // Capture the edge vectors of an accepted face
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ux   <= DW'(p2_x) - DW'(p1_x);
      uy   <= DW'(p2_y) - DW'(p1_y);
      uz   <= DW'(p2_z) - DW'(p1_z);
      vx   <= DW'(p3_x) - DW'(p1_x);
      vy   <= DW'(p3_y) - DW'(p1_y);
      vz   <= DW'(p3_z) - DW'(p1_z);
      kept <= !cfg.filter_enable || (face_surface == cfg.target_surface);
      last <= last_face;
    end
  end

  assign cos_ext = CM_W'(cfg.cos_threshold);
  assign cneg    = cfg.cos_threshold[spc_pkg::COS_W-1];
  assign cmag    = cneg ? CM_W'(-cos_ext) : CM_W'(cos_ext);

  // Select operand A
  always_comb begin
    case (cmd.op.a_sel)
      spc_pkg::A_UX:     opa = MOW'(ux);
      spc_pkg::A_UY:     opa = MOW'(uy);
      spc_pkg::A_UZ:     opa = MOW'(uz);
      spc_pkg::A_NX:     opa = MOW'(nx);
      spc_pkg::A_NY:     opa = MOW'(ny);
      spc_pkg::A_NZ:     opa = MOW'(nz);
      spc_pkg::A_LEN_LO: opa = MOW'(len[MW-1:0]);
      spc_pkg::A_LEN_HI: opa = MOW'(len[LW-1:MW]);
      spc_pkg::A_D_LO:   opa = MOW'(dmag[MW-1:0]);
      spc_pkg::A_D_HI:   opa = MOW'(dmag[LW-1:MW]);
      spc_pkg::A_P0:     opa = MOW'(plen[MW-1:0]);
      spc_pkg::A_P1:     opa = MOW'(plen[2*MW-1:MW]);
      spc_pkg::A_P2:     opa = MOW'(plen[3*MW-1:2*MW]);
      spc_pkg::A_P3:     opa = MOW'(plen[4*MW-1:3*MW]);
      default:           opa = '0;
    endcase
  end

  // Select operand B
  always_comb begin
    case (cmd.op.b_sel)
      spc_pkg::B_VX:      opb = MOW'(vx);
      spc_pkg::B_VY:      opb = MOW'(vy);
      spc_pkg::B_VZ:      opb = MOW'(vz);
      spc_pkg::B_NX:      opb = MOW'(nx);
      spc_pkg::B_NY:      opb = MOW'(ny);
      spc_pkg::B_NZ:      opb = MOW'(nz);
      spc_pkg::B_RX:      opb = MOW'(ref_x);
      spc_pkg::B_RY:      opb = MOW'(ref_y);
      spc_pkg::B_RZ:      opb = MOW'(ref_z);
      spc_pkg::B_RLEN_LO: opb = MOW'(ref_len[MW-1:0]);
      spc_pkg::B_RLEN_HI: opb = MOW'(ref_len[LW-1:MW]);
      spc_pkg::B_D_LO:    opb = MOW'(dmag[MW-1:0]);
      spc_pkg::B_D_HI:    opb = MOW'(dmag[LW-1:MW]);
      spc_pkg::B_CMAG:    opb = MOW'(cmag);
      default:            opb = '0;
    endcase
  end

  // Register the product with its accumulate controls
  always_ff @(posedge clk) begin
    prod    <= opa * opb;
    shift_q <= cmd.op.shift;
    clr_q   <= cmd.op.clr;
    neg_q   <= cmd.op.neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd.op.acc_en;
    end
  end

  // Align the product to its limb and add it in
  assign term = ACC_W'(prod);

  always_comb begin
    case (shift_q)
      2'd0:    shifted = term;
      2'd1:    shifted = term << MW;
      2'd2:    shifted = term << (2 * MW);
      default: shifted = term << (3 * MW);
    endcase
    if (clr_q) begin
      acc_next = neg_q ? -shifted : shifted;
    end else begin
      acc_next = neg_q ? acc - shifted : acc + shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_en_q) begin
      acc <= acc_next;
    end
  end

  // Store finished sums
  always_ff @(posedge clk) begin
    case (cmd.op.st)
      spc_pkg::ST_NX:  nx   <= acc[MW-1:0];
      spc_pkg::ST_NY:  ny   <= acc[MW-1:0];
      spc_pkg::ST_NZ:  nz   <= acc[MW-1:0];
      spc_pkg::ST_LEN: len  <= acc[LW-1:0];
      spc_pkg::ST_D: begin
        dneg <= acc[ACC_W-1];
        dmag <= acc[ACC_W-1] ? LW'(-acc) : LW'(acc);
      end
      spc_pkg::ST_P:   plen <= acc[PW-1:0];
      spc_pkg::ST_D2:  d2   <= acc[PW-1:0];
      default: ;
    endcase
  end

  // Capture the reference normal from the first kept face
  always_ff @(posedge clk) begin
    if (cmd.st_ref) begin
      ref_x   <= nx;
      ref_y   <= ny;
      ref_z   <= nz;
      ref_len <= acc[LW-1:0];
    end
  end

  // Signed compare of d*|d|*2^15 against c*|n|^2*|r|^2 by magnitudes
  assign amag = ACC_W'(d2) << spc_pkg::COS_FRAC;
  assign bmag = acc;

  always_comb begin
    if (dneg) begin
      dev_now = cneg ? (bmag < amag) : 1'b1;
    end else begin
      dev_now = !cneg && (amag < bmag);
    end
  end

  // Hold the reference and sticky deviation flags until the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      have_ref <= 1'b0;
      dev      <= 1'b0;
    end else if (cmd.emit) begin
      have_ref <= 1'b0;
      dev      <= 1'b0;
    end else begin
      if (cmd.st_ref) begin
        have_ref <= 1'b1;
      end
      if (cmd.op.fin && dev_now) begin
        dev <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      is_planar <= !dev;
    end
  end

endmodule

>>> rtl/spc_controller.sv
module spc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  spc_pkg::status_t st,
  output spc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [spc_pkg::STEP_W-1:0] LAST_STEP = spc_pkg::STEP_W'(spc_pkg::PROG_LEN - 1);

  state_t                      state, state_next;
  logic [spc_pkg::STEP_W-1:0]  step, step_next;
  spc_pkg::uop_t               op;

  assign op         = spc_pkg::uop_at(step);
  assign face_ready = (state == S_IDLE);

  // Sequence one face through the microprogram
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (face_valid) begin
          cmd.capture = 1'b1;
          step_next   = '0;
          state_next  = S_RUN;
        end
      end
      S_RUN: begin
        if (!st.kept) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = op;
          cmd.st_ref = op.ref_pt && !st.have_ref;
          if ((op.ref_pt && !st.have_ref) || op.fin) begin
            state_next = S_DONE;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!st.last) begin
          state_next = S_IDLE;
        end else if (!result_valid || result_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Hold the result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // A verdict never overwrites a result still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || result_ready))
    else $error("verdict issued while result slot busy");

  // The step counter stays inside the microprogram
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step <= LAST_STEP))
    else $error("step counter ran past the microprogram");

  // A compare only runs against a captured reference
  a_cmp_ref: assert property (@(posedge clk) disable iff (rst)
    cmd.op.fin |-> st.have_ref)
    else $error("compare issued without a reference");

  // A skipped face issues no arithmetic and finishes next cycle
  a_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && !st.kept) |=> (state == S_DONE && !$past(cmd.op.acc_en)))
    else $error("skipped face was processed");

endmodule

>>> rtl/surface_planarity_check.sv
// Channel  | handshake                  | payload
// face     | face_valid / face_ready    | face_surface, p1_x..p3_z, last_face
// result   | result_valid / result_ready| is_planar
// config   | cfg_wr_en                  | cfg_index, cfg_wr_data
//
// A skipped face issues no products, the first kept face stops at the reference step
// and every later kept face runs to the end: one shared signed multiplier steps
// through a 26-step microprogram, at most one partial product per cycle.
// Reset (rst, synchronous) clears the reference, the deviation flag and the
// result slot; the registers return to their defaults.
// A waiting result blocks only a final face, which holds until the slot empties.
module surface_planarity_check #(
  parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [spc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic                              face_valid,
  output logic                              face_ready,
  input  logic [spc_pkg::SURFACE_W-1:0]     face_surface,
  input  logic signed [COORD_BITS-1:0]      p1_x,
  input  logic signed [COORD_BITS-1:0]      p1_y,
  input  logic signed [COORD_BITS-1:0]      p1_z,
  input  logic signed [COORD_BITS-1:0]      p2_x,
  input  logic signed [COORD_BITS-1:0]      p2_y,
  input  logic signed [COORD_BITS-1:0]      p2_z,
  input  logic signed [COORD_BITS-1:0]      p3_x,
  input  logic signed [COORD_BITS-1:0]      p3_y,
  input  logic signed [COORD_BITS-1:0]      p3_z,
  input  logic                              last_face,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              is_planar
);

  spc_pkg::cfg_t    cfg;
  spc_pkg::cmd_t    cmd;
  spc_pkg::status_t st;

  // Decode configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_surface <= spc_pkg::TARGET_SURFACE_RST;
      cfg.filter_enable  <= spc_pkg::FILTER_ENABLE_RST;
      cfg.cos_threshold  <= spc_pkg::COS_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        spc_pkg::CFG_TARGET_SURFACE: cfg.target_surface <= cfg_wr_data;
        spc_pkg::CFG_FILTER_ENABLE:  cfg.filter_enable  <= cfg_wr_data[0];
        spc_pkg::CFG_COS_THRESHOLD:  cfg.cos_threshold  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  spc_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .face_valid   (face_valid),
    .face_ready   (face_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .st           (st),
    .cmd          (cmd)
  );

  spc_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .face_surface (face_surface),
    .p1_x         (p1_x),
    .p1_y         (p1_y),
    .p1_z         (p1_z),
    .p2_x         (p2_x),
    .p2_y         (p2_y),
    .p2_z         (p2_z),
    .p3_x         (p3_x),
    .p3_y         (p3_y),
    .p3_z         (p3_z),
    .last_face    (last_face),
    .is_planar    (is_planar)
  );

endmodule

>>> tb/tb_surface_planarity_check.sv
module tb_surface_planarity_check;

  localparam int CB           = spc_pkg::COORD_BITS_DEF;
  localparam int SURFACE_W    = spc_pkg::SURFACE_W;
  localparam int COS_W        = spc_pkg::COS_W;
  localparam int CFG_INDEX_W  = spc_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W   = spc_pkg::CFG_DATA_W;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 9;
  localparam int PHASE_FACES  = 120;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic [SURFACE_W-1:0] surface;
    logic signed [CB-1:0] pt [3][3];
    logic                 last;
  } face_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;
  logic                   face_valid;
  logic                   face_ready;
  logic [SURFACE_W-1:0]   face_surface;
  logic signed [CB-1:0]   p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
  logic                   last_face;
  logic                   result_valid;
  logic                   result_ready;
  logic                   is_planar;

  // Register shadow and running planarity state
  logic [SURFACE_W-1:0]   cfg_target = spc_pkg::TARGET_SURFACE_RST;
  logic                   cfg_filter = spc_pkg::FILTER_ENABLE_RST;
  logic signed [COS_W-1:0] cfg_cos   = spc_pkg::COS_THRESHOLD_RST;
  longint                 ref_nx, ref_ny, ref_nz;
  wide_t                  ref_len_sq;
  bit                     have_ref;
  bit                     dev_found;

  bit                     verdict_q [$];
  int                     mismatches;
  int                     cycles;
  bit                     steady;
  bit                     hold_request;
  bit                     verdict_exp;
  int                     plane_org [3];
  int                     plane_e1 [3];
  int                     plane_e2 [3];

  surface_planarity_check #(.COORD_BITS(CB)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .face_valid   (face_valid),
    .face_ready   (face_ready),
    .face_surface (face_surface),
    .p1_x         (p1_x),
    .p1_y         (p1_y),
    .p1_z         (p1_z),
    .p2_x         (p2_x),
    .p2_y         (p2_y),
    .p2_z         (p2_z),
    .p3_x         (p3_x),
    .p3_y         (p3_y),
    .p3_z         (p3_z),
    .last_face    (last_face),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_planar    (is_planar)
  );

  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_surface_planarity_check NOT OK");
      $finish;
    end
  end

  // Apply one accepted face to the running state; queue the verdict on a final face
  task automatic accumulate_face(input face_t f);
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
    wide_t  wx, wy, wz, rx, ry, rz, dot, len_sq, lhs, rhs, cos_w;
    if (!cfg_filter || f.surface == cfg_target) begin
      ux = longint'(f.pt[1][0]) - longint'(f.pt[0][0]);
      uy = longint'(f.pt[1][1]) - longint'(f.pt[0][1]);
      uz = longint'(f.pt[1][2]) - longint'(f.pt[0][2]);
      vx = longint'(f.pt[2][0]) - longint'(f.pt[0][0]);
      vy = longint'(f.pt[2][1]) - longint'(f.pt[0][1]);
      vz = longint'(f.pt[2][2]) - longint'(f.pt[0][2]);
      nx = uy * vz - uz * vy;
      ny = uz * vx - ux * vz;
      nz = ux * vy - uy * vx;
      wx = nx;
      wy = ny;
      wz = nz;
      len_sq = wx * wx + wy * wy + wz * wz;
      if (!have_ref) begin
        ref_nx     = nx;
        ref_ny     = ny;
        ref_nz     = nz;
        ref_len_sq = len_sq;
        have_ref   = 1'b1;
      end else begin
        // signed squared cosine against the threshold, cross-multiplied
        rx  = ref_nx;
        ry  = ref_ny;
        rz  = ref_nz;
        dot = wx * rx + wy * ry + wz * rz;
        lhs = dot * dot;
        if (dot < 0) lhs = -lhs;
        lhs   = lhs * 32768;
        cos_w = cfg_cos;
        rhs   = cos_w * len_sq * ref_len_sq;
        if (lhs < rhs) dev_found = 1'b1;
      end
    end
    if (f.last) begin
      verdict_q.push_back(!dev_found);
      ref_nx     = 0;
      ref_ny     = 0;
      ref_nz     = 0;
      ref_len_sq = '0;
      have_ref   = 1'b0;
      dev_found  = 1'b0;
    end
  endtask

  function automatic face_t mk_face(input logic [SURFACE_W-1:0] surf,
                                    input int x1, y1, z1, x2, y2, z2, x3, y3, z3,
                                    input logic last);
    face_t f;
    f.surface  = surf;
    f.pt[0][0] = CB'(x1);
    f.pt[0][1] = CB'(y1);
    f.pt[0][2] = CB'(z1);
    f.pt[1][0] = CB'(x2);
    f.pt[1][1] = CB'(y2);
    f.pt[1][2] = CB'(z2);
    f.pt[2][0] = CB'(x3);
    f.pt[2][1] = CB'(y3);
    f.pt[2][2] = CB'(z3);
    f.last     = last;
    return f;
  endfunction

  // Pick a plane for the next mesh: origin plus two small spanning vectors
  task automatic new_plane;
    for (int j = 0; j < 3; j++) begin
      plane_org[j] = int'($urandom_range(0, 2400)) - 1200;
      plane_e1[j]  = int'($urandom_range(0, 30)) - 15;
      plane_e2[j]  = int'($urandom_range(0, 30)) - 15;
    end
  endtask

  // Mostly faces on the current plane, some nudged off it, some pure noise
  function automatic face_t random_face(input logic last);
    face_t f;
    int    a, b, vi, ai;
    f.last = last;
    if ($urandom_range(99) < 15) begin
      f.surface = SURFACE_W'($urandom);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          f.pt[i][j] = CB'($urandom);
    end else begin
      if (cfg_filter && $urandom_range(99) < 75) f.surface = cfg_target;
      else f.surface = SURFACE_W'($urandom);
      for (int i = 0; i < 3; i++) begin
        a = int'($urandom_range(0, 30)) - 15;
        b = int'($urandom_range(0, 30)) - 15;
        for (int j = 0; j < 3; j++)
          f.pt[i][j] = CB'(plane_org[j] + a * plane_e1[j] + b * plane_e2[j]);
      end
      if ($urandom_range(99) < 30) begin
        vi = $urandom_range(0, 2);
        ai = $urandom_range(0, 2);
        f.pt[vi][ai] = f.pt[vi][ai] + CB'(int'($urandom_range(0, 8)) - 4);
      end
    end
    return f;
  endfunction

  // Offer one face, hold it until accepted, then update the prediction
  task automatic send_face(input face_t f);
    if (!steady && $urandom_range(99) < 13) begin
      face_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    face_valid   <= 1'b1;
    face_surface <= f.surface;
    p1_x         <= f.pt[0][0];
    p1_y         <= f.pt[0][1];
    p1_z         <= f.pt[0][2];
    p2_x         <= f.pt[1][0];
    p2_y         <= f.pt[1][1];
    p2_z         <= f.pt[1][2];
    p3_x         <= f.pt[2][0];
    p3_y         <= f.pt[2][1];
    p3_z         <= f.pt[2][2];
    last_face    <= f.last;
    do @(posedge clk); while (!face_ready);
    accumulate_face(f);
  endtask

  task automatic send_mesh(input int n);
    new_plane();
    for (int i = 0; i < n; i++) send_face(random_face(i == n - 1));
  endtask

  // Drop valid, wait for every verdict, then let trailing faces finish
  task automatic settle;
    face_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    case (idx)
      spc_pkg::CFG_TARGET_SURFACE: cfg_target = data;
      spc_pkg::CFG_FILTER_ENABLE:  cfg_filter = data[0];
      spc_pkg::CFG_COS_THRESHOLD:  cfg_cos    = data;
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Reset thresholds: a parallel pair, then a lone final face
  task automatic test_defaults;
    send_face(mk_face(16'd0, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd123, 7, -3, 50, 207, -3, 50, 7, 197, 50, 1'b1));
    send_face(mk_face(16'hFFFF, 1, 2, 3, 4, 5, 6, 7, 8, 10, 1'b1));
    settle();
  endtask

  // Coordinate extremes, degenerate faces, faces after a deviation
  task automatic test_extremes;
    send_face(mk_face(16'h5A5A, -2048, -2048, -2048, 2047, -2048, -2048,
                      -2048, 2047, -2048, 1'b0));
    send_face(mk_face(16'hA5A5, 2047, 2047, 2047, 2047, -2048, 2047,
                      -2048, 2047, 2047, 1'b1));
    // zero reference normal
    send_face(mk_face(16'd1, 1, 1, 1, 2, 2, 2, 3, 3, 3, 1'b0));
    send_face(mk_face(16'd1, 0, 0, 0, 100, 0, 10, 0, 100, 0, 1'b1));
    // zero face normal against a real reference
    send_face(mk_face(16'd2, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd2, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 1'b0));
    send_face(mk_face(16'd2, 7, -3, 50, 207, -3, 50, 7, 197, 50, 1'b1));
    // deviation stays set through a later parallel face
    send_face(mk_face(16'd3, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd3, 0, 0, 0, 100, 0, 10, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd3, 7, -3, 50, 207, -3, 50, 7, 197, 50, 1'b1));
    settle();
  endtask

  // Surface filtering, including skipped final faces
  task automatic test_filter;
    write_reg(spc_pkg::CFG_TARGET_SURFACE, 16'hFFFF);
    write_reg(spc_pkg::CFG_FILTER_ENABLE, 16'h0001);
    send_face(mk_face(16'h0000, 0, 0, 0, 100, 0, 10, 0, 100, 0, 1'b1));
    send_face(mk_face(16'hFFFF, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'hFFFE, 0, 0, 0, 100, 0, 10, 0, 100, 0, 1'b0));
    send_face(mk_face(16'hFFFF, 7, -3, 50, 207, -3, 50, 7, 197, 50, 1'b1));
    send_face(mk_face(16'hFFFF, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'hFFFF, 0, 0, 0, 100, 0, 10, 0, 100, 0, 1'b0));
    send_face(mk_face(16'h0000, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b1));
    settle();
  endtask

  // Threshold extremes with opposite and perpendicular normals
  task automatic test_threshold;
    write_reg(spc_pkg::CFG_FILTER_ENABLE, 16'hFFFE);
    write_reg(spc_pkg::CFG_COS_THRESHOLD, 16'h8000);
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd9, 0, 0, 0, 0, 100, 0, 100, 0, 0, 1'b0));
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b1));
    settle();
    write_reg(spc_pkg::CFG_COS_THRESHOLD, 16'h0000);
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd9, 0, 0, 0, 0, 100, 0, 100, 0, 0, 1'b1));
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b1));
    settle();
    write_reg(spc_pkg::CFG_COS_THRESHOLD, 16'h0001);
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 100, 0, 1'b0));
    send_face(mk_face(16'd9, 0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b1));
    settle();
  endtask

  // Hold off the result side while short meshes keep arriving
  task automatic test_backpressure;
    int sent;
    sent         = 0;
    steady       = 1'b1;
    hold_request = 1'b1;
    while (sent < 80) begin
      send_mesh($urandom_range(1, 3));
      sent = sent + 1;
    end
    settle();
    steady = 1'b0;
  endtask

  // Random meshes over several register settings; first phase runs without idling
  task automatic test_random;
    int                      sent, n;
    logic [COS_W-1:0]        cos_v;
    logic [SURFACE_W-1:0]    target_v;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       cos_v = COS_W'($urandom);
        1:       cos_v = COS_W'($urandom_range(32000, 32767));
        2:       cos_v = COS_W'($urandom_range(25000, 32767));
        default: cos_v = COS_W'($urandom_range(0, 32767));
      endcase
      if (p == 1) cos_v = 16'h8000;
      if (p == 2) cos_v = 16'h7FFF;
      if (p == 4) cos_v = 16'h0000;
      if (p == 3) target_v = 16'hFFFF;
      else if ($urandom_range(1)) target_v = SURFACE_W'($urandom_range(0, 7));
      else target_v = SURFACE_W'($urandom);
      write_reg(spc_pkg::CFG_TARGET_SURFACE, target_v);
      write_reg(spc_pkg::CFG_FILTER_ENABLE, {15'($urandom), p[0]});
      write_reg(spc_pkg::CFG_COS_THRESHOLD, cos_v);
      steady = (p == 0);
      sent   = 0;
      while (sent < PHASE_FACES) begin
        if ($urandom_range(99) < 20) n = $urandom_range(1, 3);
        else n = $urandom_range(4, 40);
        send_mesh(n);
        sent = sent + n;
      end
      settle();
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, or a long hold-off on request
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  // Compare each verdict with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (verdict_q.size() == 0) begin
        $error("is_planar: unexpected transaction, actual %0b", is_planar);
        mismatches++;
      end else begin
        verdict_exp = verdict_q.pop_front();
        if (is_planar !== verdict_exp) begin
          $error("is_planar: expected %0b actual %0b", verdict_exp, is_planar);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wr_data  = '0;
    face_valid   = 1'b0;
    face_surface = '0;
    p1_x = '0; p1_y = '0; p1_z = '0;
    p2_x = '0; p2_y = '0; p2_z = '0;
    p3_x = '0; p3_y = '0; p3_z = '0;
    last_face    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_extremes();
    test_filter();
    test_threshold();
    test_backpressure();
    test_random();
    settle();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("tb_surface_planarity_check OK");
    end else begin
      $display("tb_surface_planarity_check NOT OK");
    end
    $finish;
  end

endmodule
